/* hw/rtl/vrs_pkg.sv */
package vrs_pkg;

    localparam int PALETTE_BYTES = 768;
    localparam int CRTC_REGS     = 25;
    localparam int GFX_REGS      = 10;
    localparam int SEQ_REGS      = 7;
    localparam int SEQ_WR_MAX    = 5;
    localparam int ATT_REGS      = 21;

    localparam int PTR_W     = 10;
    localparam int PAL_AW    = $clog2(PALETTE_BYTES);
    localparam int REG_IW    = 6;
    localparam int REG_AW    = REG_IW + 2;
    localparam int REG_DEPTH = 1 << REG_AW;
    localparam int CLR_LEN   = (PALETTE_BYTES > REG_DEPTH) ? PALETTE_BYTES : REG_DEPTH;
    localparam int CLR_W     = $clog2(CLR_LEN);
    localparam int LOAD_QB   = $clog2((765 / PALETTE_BYTES) + 1);

    localparam logic [1:0] GRP_CRTC = 2'd0;
    localparam logic [1:0] GRP_GFX  = 2'd1;
    localparam logic [1:0] GRP_SEQ  = 2'd2;
    localparam logic [1:0] GRP_ATT  = 2'd3;

    localparam logic CFG_STATUS0 = 1'b0;
    localparam logic CFG_STATUS1 = 1'b1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [9:0] PORT_CRTC_IDX_C = 10'h3D4;
    localparam logic [9:0] PORT_CRTC_IDX_M = 10'h3B4;
    localparam logic [9:0] PORT_CRTC_DAT_C = 10'h3D5;
    localparam logic [9:0] PORT_CRTC_DAT_M = 10'h3B5;
    localparam logic [9:0] PORT_GFX_IDX    = 10'h3CE;
    localparam logic [9:0] PORT_GFX_DAT    = 10'h3CF;
    localparam logic [9:0] PORT_SEQ_IDX    = 10'h3C4;
    localparam logic [9:0] PORT_SEQ_DAT    = 10'h3C5;
    localparam logic [9:0] PORT_ATT_IDX    = 10'h3C0;
    localparam logic [9:0] PORT_ATT_RD     = 10'h3C1;
    localparam logic [9:0] PORT_STAT1_C    = 10'h3DA;
    localparam logic [9:0] PORT_STAT1_M    = 10'h3BA;
    localparam logic [9:0] PORT_MISC_RD    = 10'h3CC;
    localparam logic [9:0] PORT_MISC_WR    = 10'h3C2;
    localparam logic [9:0] PORT_DAC_WIDX   = 10'h3C8;
    localparam logic [9:0] PORT_DAC_RIDX   = 10'h3C7;
    localparam logic [9:0] PORT_DAC_DATA   = 10'h3C9;
    localparam logic [9:0] PORT_PEL_MASK   = 10'h3C6;
    localparam logic [9:0] PORT_GPOS2      = 10'h3CA;

    typedef enum logic [1:0] {SRC_IMM, SRC_REG, SRC_PAL} t_src;
    typedef enum logic {ST_CLEAR, ST_RUN} t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [REG_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_reg_req;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [PAL_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_pal_req;

    typedef struct packed {
        t_src       src;
        logic [7:0] imm;
        logic       pass;
    } t_resp;

    function automatic logic [7:0] dac_div3(input logic [PTR_W-1:0] p);
        logic [19:0] prod;
        prod = 20'(p) * 20'd683;
        return prod[18:11];
    endfunction

    function automatic logic [PTR_W-1:0] dac_load(input logic [7:0] v);
        logic [10:0] r;
        r = {2'b00, v, 1'b0} + {3'b000, v};
        for (int k = LOAD_QB - 1; k >= 0; k--) begin
            if (r >= (11'(PALETTE_BYTES) << k)) begin
                r = r - (11'(PALETTE_BYTES) << k);
            end
        end
        return r[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] dac_next(input logic [PTR_W-1:0] p);
        if (p >= PTR_W'(PALETTE_BYTES - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

endpackage

/* hw/rtl/vrs_ram.sv */
module vrs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/vrs_ctrl.sv */
module vrs_ctrl
    import vrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic       i_cmd,
    input  logic [9:0] i_port,
    input  logic [7:0] i_wr_value,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_run,
    output t_reg_req   o_reg_req,
    output t_pal_req   o_pal_req,
    output t_resp      o_resp
);

    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr_cnt;

    logic [7:0]       r_status0, r_status1;
    logic [7:0]       r_crtc_index, n_crtc_index;
    logic [7:0]       r_gfx_index, n_gfx_index;
    logic [7:0]       r_seq_index, n_seq_index;
    logic [4:0]       r_att_index, n_att_index;
    logic             r_next_is_index, n_next_is_index;
    logic [7:0]       r_misc, n_misc;
    logic [PTR_W-1:0] r_dac_wptr, n_dac_wptr;
    logic [PTR_W-1:0] r_dac_rptr, n_dac_rptr;
    logic [7:0]       r_pel_mask, n_pel_mask;
    logic [7:0]       r_gpos1, n_gpos1;
    logic [7:0]       r_gpos2, n_gpos2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_W'(CLR_LEN - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:  n_state = ST_RUN;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_run = (r_state == ST_RUN);
    end

    always_comb begin
        n_crtc_index    = r_crtc_index;
        n_gfx_index     = r_gfx_index;
        n_seq_index     = r_seq_index;
        n_att_index     = r_att_index;
        n_next_is_index = r_next_is_index;
        n_misc          = r_misc;
        n_dac_wptr      = r_dac_wptr;
        n_dac_rptr      = r_dac_rptr;
        n_pel_mask      = r_pel_mask;
        n_gpos1         = r_gpos1;
        n_gpos2         = r_gpos2;
        o_reg_req       = '{we: 1'b0, re: 1'b0, addr: '0, wdata: i_wr_value};
        o_pal_req       = '{we: 1'b0, re: 1'b0, addr: '0, wdata: i_wr_value};
        o_resp          = '{src: SRC_IMM, imm: 8'h00, pass: 1'b0};

        if (r_state == ST_CLEAR) begin
            o_reg_req.we    = 1'b1;
            o_reg_req.addr  = r_clr_cnt[REG_AW-1:0];
            o_reg_req.wdata = 8'h00;
            o_pal_req.we    = (32'(r_clr_cnt) < PALETTE_BYTES);
            o_pal_req.addr  = r_clr_cnt[PAL_AW-1:0];
            o_pal_req.wdata = 8'h00;
        end else if (i_acc && (i_cmd == CMD_READ)) begin
            case (i_port)
                PORT_CRTC_IDX_C, PORT_CRTC_IDX_M: o_resp.imm = r_crtc_index;
                PORT_CRTC_DAT_C, PORT_CRTC_DAT_M: begin
                    if (r_crtc_index < 8'(CRTC_REGS)) begin
                        o_reg_req.re   = 1'b1;
                        o_reg_req.addr = {GRP_CRTC, r_crtc_index[REG_IW-1:0]};
                        o_resp.src     = SRC_REG;
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_GFX_IDX: o_resp.imm = r_gfx_index;
                PORT_GFX_DAT: begin
                    if (r_gfx_index < 8'(GFX_REGS)) begin
                        o_reg_req.re   = 1'b1;
                        o_reg_req.addr = {GRP_GFX, r_gfx_index[REG_IW-1:0]};
                        o_resp.src     = SRC_REG;
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_SEQ_IDX: o_resp.imm = r_seq_index;
                PORT_SEQ_DAT: begin
                    if (r_seq_index < 8'(SEQ_REGS)) begin
                        o_reg_req.re   = 1'b1;
                        o_reg_req.addr = {GRP_SEQ, r_seq_index[REG_IW-1:0]};
                        o_resp.src     = SRC_REG;
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_ATT_IDX: o_resp.imm = {3'b000, r_att_index};
                PORT_ATT_RD: begin
                    if (r_att_index < 5'(ATT_REGS)) begin
                        o_reg_req.re   = 1'b1;
                        o_reg_req.addr = {GRP_ATT, 1'b0, r_att_index};
                        o_resp.src     = SRC_REG;
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_STAT1_C, PORT_STAT1_M: begin
                    n_next_is_index = 1'b1;
                    o_resp.imm      = r_status1;
                end
                PORT_MISC_RD:  o_resp.imm = r_misc;
                PORT_MISC_WR:  o_resp.imm = r_status0;
                PORT_DAC_WIDX: o_resp.imm = dac_div3(r_dac_wptr);
                PORT_DAC_RIDX: o_resp.imm = dac_div3(r_dac_rptr);
                PORT_DAC_DATA: begin
                    o_pal_req.re   = 1'b1;
                    o_pal_req.addr = r_dac_rptr[PAL_AW-1:0];
                    o_resp.src     = SRC_PAL;
                    n_dac_rptr     = dac_next(r_dac_rptr);
                end
                PORT_PEL_MASK: o_resp.imm = (r_pel_mask == 8'h00) ? 8'hFF : r_pel_mask;
                default:       o_resp.pass = 1'b1;
            endcase
        end else if (i_acc) begin
            case (i_port)
                PORT_CRTC_IDX_C, PORT_CRTC_IDX_M: n_crtc_index = i_wr_value;
                PORT_CRTC_DAT_C, PORT_CRTC_DAT_M: begin
                    if (r_crtc_index < 8'(CRTC_REGS)) begin
                        o_reg_req.we   = 1'b1;
                        o_reg_req.addr = {GRP_CRTC, r_crtc_index[REG_IW-1:0]};
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_GFX_IDX: n_gfx_index = i_wr_value;
                PORT_GFX_DAT: begin
                    if (r_gfx_index < 8'(GFX_REGS)) begin
                        o_reg_req.we   = 1'b1;
                        o_reg_req.addr = {GRP_GFX, r_gfx_index[REG_IW-1:0]};
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_SEQ_IDX: n_seq_index = i_wr_value;
                PORT_SEQ_DAT: begin
                    if (r_seq_index <= 8'(SEQ_WR_MAX)) begin
                        o_reg_req.we   = 1'b1;
                        o_reg_req.addr = {GRP_SEQ, r_seq_index[REG_IW-1:0]};
                    end else begin
                        o_resp.pass = 1'b1;
                    end
                end
                PORT_ATT_IDX: begin
                    if (r_next_is_index) begin
                        n_att_index     = i_wr_value[4:0];
                        n_next_is_index = 1'b0;
                    end else begin
                        n_next_is_index = 1'b1;
                        if (r_att_index < 5'(ATT_REGS)) begin
                            o_reg_req.we   = 1'b1;
                            o_reg_req.addr = {GRP_ATT, 1'b0, r_att_index};
                        end else begin
                            o_resp.pass = 1'b1;
                        end
                    end
                end
                PORT_MISC_WR:  n_misc = i_wr_value;
                PORT_DAC_WIDX: n_dac_wptr = dac_load(i_wr_value);
                PORT_DAC_RIDX: n_dac_rptr = dac_load(i_wr_value);
                PORT_DAC_DATA: begin
                    o_pal_req.we   = 1'b1;
                    o_pal_req.addr = r_dac_wptr[PAL_AW-1:0];
                    n_dac_wptr     = dac_next(r_dac_wptr);
                end
                PORT_PEL_MASK: n_pel_mask = i_wr_value;
                PORT_MISC_RD:  n_gpos1 = i_wr_value;
                PORT_GPOS2:    n_gpos2 = i_wr_value;
                default:       o_resp.pass = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr_cnt       <= '0;
            r_status0       <= '0;
            r_status1       <= '0;
            r_crtc_index    <= '0;
            r_gfx_index     <= '0;
            r_seq_index     <= '0;
            r_att_index     <= '0;
            r_next_is_index <= 1'b0;
            r_misc          <= '0;
            r_dac_wptr      <= '0;
            r_dac_rptr      <= '0;
            r_pel_mask      <= '0;
            r_gpos1         <= '0;
            r_gpos2         <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_we && (i_cfg_index == CFG_STATUS0)) begin
                r_status0 <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_index == CFG_STATUS1)) begin
                r_status1 <= i_cfg_wdata;
            end
            r_crtc_index    <= n_crtc_index;
            r_gfx_index     <= n_gfx_index;
            r_seq_index     <= n_seq_index;
            r_att_index     <= n_att_index;
            r_next_is_index <= n_next_is_index;
            r_misc          <= n_misc;
            r_dac_wptr      <= n_dac_wptr;
            r_dac_rptr      <= n_dac_rptr;
            r_pel_mask      <= n_pel_mask;
            r_gpos1         <= n_gpos1;
            r_gpos2         <= n_gpos2;
        end
    end

endmodule

/* hw/rtl/vga_register_shadow.sv */
// An accepted beat passes the stage-one register, then the output register.
// Throughput: one access per cycle unless the output stalls; the register
// file and palette memory each take at most one read or write per access,
// with the read data registered. Reset: synchronous and active low. After
// reset it clears both memories, one entry per cycle, before taking beats.
module vga_register_shadow
    import vrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cmd [0], port [10:1], wr_value [18:11]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // read_data [7:0]
    output logic        m_axis_tuser,   // passed_on [0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    logic       run;
    logic       acc;
    logic       s1_move;
    t_reg_req   reg_req;
    t_pal_req   pal_req;
    t_resp      resp;
    logic [7:0] reg_rdata;
    logic [7:0] pal_rdata;
    logic [7:0] s1_data;

    logic       r_s1_valid;
    t_resp      r_s1_resp;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_pass;

    assign s1_move       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = run && (!r_s1_valid || s1_move);
    assign acc           = s_axis_tvalid && s_axis_tready;

    vrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_cmd       (s_axis_tdata[0]),
        .i_port      (s_axis_tdata[10:1]),
        .i_wr_value  (s_axis_tdata[18:11]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_run       (run),
        .o_reg_req   (reg_req),
        .o_pal_req   (pal_req),
        .o_resp      (resp)
    );

    vrs_ram #(.DEPTH(REG_DEPTH), .WIDTH(8)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_req.we),
        .i_re    (reg_req.re),
        .i_addr  (reg_req.addr),
        .i_wdata (reg_req.wdata),
        .o_rdata (reg_rdata)
    );

    vrs_ram #(.DEPTH(PALETTE_BYTES), .WIDTH(8)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_req.we),
        .i_re    (pal_req.re),
        .i_addr  (pal_req.addr),
        .i_wdata (pal_req.wdata),
        .o_rdata (pal_rdata)
    );

    always_comb begin
        case (r_s1_resp.src)
            SRC_REG: s1_data = reg_rdata;
            SRC_PAL: s1_data = pal_rdata;
            default: s1_data = r_s1_resp.imm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_resp <= resp;
        end
        if (s1_move && r_s1_valid) begin
            r_out_data <= s1_data;
            r_out_pass <= r_s1_resp.pass;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_pass;

endmodule

/* hw/rtl/vrs_checker.sv */
module vrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser
);

    // A passed-on access never returns data.
    a_pass_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("passed-on beat carries nonzero data");

    // The memory clearing pass keeps the input side closed after reset.
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during memory clearing");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind vga_register_shadow vrs_checker u_vrs_checker (.*);

/* tb/tb_vga_register_shadow.sv */
module tb_vga_register_shadow;
    import vrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 200;
    localparam int NUM_DIRECTED  = 26;
    localparam int NUM_VGA_PORTS = 20;

    localparam logic [9:0] PORT_STAT0 = PORT_MISC_WR;
    localparam logic [9:0] PORT_GPOS1 = PORT_MISC_RD;

    typedef struct packed {
        logic       cmd;
        logic [9:0] port;
        logic [7:0] value;
    } t_access;

    typedef struct packed {
        logic [7:0] data;
        logic       pass;
    } t_reply;

    typedef struct packed {
        t_access acc;
        logic    typed;
        t_reply  want;
    } t_row;

    localparam t_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{'{CMD_READ,  PORT_CRTC_IDX_C, 8'h00}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_READ,  PORT_PEL_MASK,   8'h00}, 1'b1, '{8'hFF, 1'b0}},
        '{'{CMD_READ,  10'h000,         8'h00}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_WRITE, 10'h3FF,         8'hFF}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_WRITE, PORT_CRTC_IDX_M, 8'h18}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_CRTC_DAT_C, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
        '{'{CMD_READ,  PORT_CRTC_DAT_M, 8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_CRTC_IDX_C, 8'h19}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,  PORT_CRTC_DAT_C, 8'h00}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_WRITE, PORT_GFX_IDX,    8'h0A}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_GFX_DAT,    8'h3C}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_WRITE, PORT_SEQ_IDX,    8'h06}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_SEQ_DAT,    8'h77}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_READ,  PORT_STAT1_M,    8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_ATT_IDX,    8'hFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_ATT_IDX,    8'h44}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_READ,  PORT_ATT_RD,     8'h00}, 1'b1, '{8'h00, 1'b1}},
        '{'{CMD_WRITE, PORT_MISC_WR,    8'hC3}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_DAC_WIDX,   8'hFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_DAC_DATA,   8'h81}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_DAC_DATA,   8'h7E}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_DAC_DATA,   8'h55}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,  PORT_DAC_WIDX,   8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_DAC_RIDX,   8'hFF}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_READ,  PORT_DAC_DATA,   8'h00}, 1'b0, '{8'h00, 1'b0}},
        '{'{CMD_WRITE, PORT_GPOS2,      8'h5A}, 1'b0, '{8'h00, 1'b0}}
    };

    localparam logic [9:0] VGA_PORTS [NUM_VGA_PORTS] = '{
        PORT_CRTC_IDX_C, PORT_CRTC_IDX_M, PORT_CRTC_DAT_C, PORT_CRTC_DAT_M,
        PORT_GFX_IDX, PORT_GFX_DAT, PORT_SEQ_IDX, PORT_SEQ_DAT,
        PORT_ATT_IDX, PORT_ATT_RD, PORT_STAT1_C, PORT_STAT1_M,
        PORT_MISC_RD, PORT_MISC_WR, PORT_DAC_WIDX, PORT_DAC_RIDX,
        PORT_DAC_DATA, PORT_DAC_DATA, PORT_PEL_MASK, PORT_GPOS2
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;

    // Shadow copy of the register file, kept in step with accepted beats.
    logic [7:0] sh_status0 = '0;
    logic [7:0] sh_status1 = '0;
    logic [7:0] sh_crtc_idx = '0;
    logic [7:0] sh_crtc [CRTC_REGS] = '{default: 8'h00};
    logic [7:0] sh_gfx_idx = '0;
    logic [7:0] sh_gfx [GFX_REGS] = '{default: 8'h00};
    logic [7:0] sh_seq_idx = '0;
    logic [7:0] sh_seq [SEQ_REGS] = '{default: 8'h00};
    logic [4:0] sh_att_idx = '0;
    logic [7:0] sh_att [ATT_REGS] = '{default: 8'h00};
    logic       sh_att_flip = 1'b0;
    logic [7:0] sh_misc = '0;
    logic [9:0] sh_dac_wp = '0;
    logic [9:0] sh_dac_rp = '0;
    logic [7:0] sh_pal [PALETTE_BYTES] = '{default: 8'h00};
    logic [7:0] sh_pel = '0;
    logic [7:0] sh_gpos1 = '0;
    logic [7:0] sh_gpos2 = '0;

    t_reply pending_replies [$];
    t_reply mon_want;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    logic sink_hold = 1'b0;
    event hold_kick;

    int error_count = 0;
    int cycle_count = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_results = 0;
    int n_passed = 0;

    vga_register_shadow u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // cmd [0], port [10:1], wr_value [18:11]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // read_data [7:0]
        .m_axis_tuser  (m_axis_tuser),   // passed_on [0]
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [9:0] palette_ptr_inc(input logic [9:0] p);
        return (32'(p) + 1 >= PALETTE_BYTES) ? 10'd0 : p + 10'd1;
    endfunction

    function automatic t_reply shadow_access(input t_access a);
        t_reply r;
        r = '{8'h00, 1'b0};
        if (a.cmd == CMD_WRITE) begin
            case (a.port)
                PORT_CRTC_IDX_C, PORT_CRTC_IDX_M: sh_crtc_idx = a.value;
                PORT_CRTC_DAT_C, PORT_CRTC_DAT_M: begin
                    if (sh_crtc_idx < CRTC_REGS) sh_crtc[sh_crtc_idx] = a.value;
                    else r.pass = 1'b1;
                end
                PORT_GFX_IDX: sh_gfx_idx = a.value;
                PORT_GFX_DAT: begin
                    if (sh_gfx_idx < GFX_REGS) sh_gfx[sh_gfx_idx] = a.value;
                    else r.pass = 1'b1;
                end
                PORT_SEQ_IDX: sh_seq_idx = a.value;
                PORT_SEQ_DAT: begin
                    if (sh_seq_idx <= SEQ_WR_MAX) sh_seq[sh_seq_idx] = a.value;
                    else r.pass = 1'b1;
                end
                PORT_ATT_IDX: begin
                    if (sh_att_flip) begin
                        sh_att_idx = a.value[4:0];
                        sh_att_flip = 1'b0;
                    end else begin
                        sh_att_flip = 1'b1;
                        if (sh_att_idx < ATT_REGS) sh_att[sh_att_idx] = a.value;
                        else r.pass = 1'b1;
                    end
                end
                PORT_MISC_WR: sh_misc = a.value;
                PORT_DAC_WIDX: sh_dac_wp = 10'((32'(a.value) * 3) % PALETTE_BYTES);
                PORT_DAC_RIDX: sh_dac_rp = 10'((32'(a.value) * 3) % PALETTE_BYTES);
                PORT_DAC_DATA: begin
                    sh_pal[sh_dac_wp] = a.value;
                    sh_dac_wp = palette_ptr_inc(sh_dac_wp);
                end
                PORT_PEL_MASK: sh_pel = a.value;
                PORT_GPOS1: sh_gpos1 = a.value;
                PORT_GPOS2: sh_gpos2 = a.value;
                default: r.pass = 1'b1;
            endcase
        end else begin
            case (a.port)
                PORT_CRTC_IDX_C, PORT_CRTC_IDX_M: r.data = sh_crtc_idx;
                PORT_CRTC_DAT_C, PORT_CRTC_DAT_M: begin
                    if (sh_crtc_idx < CRTC_REGS) r.data = sh_crtc[sh_crtc_idx];
                    else r.pass = 1'b1;
                end
                PORT_GFX_IDX: r.data = sh_gfx_idx;
                PORT_GFX_DAT: begin
                    if (sh_gfx_idx < GFX_REGS) r.data = sh_gfx[sh_gfx_idx];
                    else r.pass = 1'b1;
                end
                PORT_SEQ_IDX: r.data = sh_seq_idx;
                PORT_SEQ_DAT: begin
                    if (sh_seq_idx < SEQ_REGS) r.data = sh_seq[sh_seq_idx];
                    else r.pass = 1'b1;
                end
                PORT_ATT_IDX: r.data = 8'(sh_att_idx);
                PORT_ATT_RD: begin
                    if (sh_att_idx < ATT_REGS) r.data = sh_att[sh_att_idx];
                    else r.pass = 1'b1;
                end
                PORT_STAT1_C, PORT_STAT1_M: begin
                    sh_att_flip = 1'b1;
                    r.data = sh_status1;
                end
                PORT_MISC_RD: r.data = sh_misc;
                PORT_STAT0: r.data = sh_status0;
                PORT_DAC_WIDX: r.data = 8'(32'(sh_dac_wp) / 3);
                PORT_DAC_RIDX: r.data = 8'(32'(sh_dac_rp) / 3);
                PORT_DAC_DATA: begin
                    r.data = sh_pal[sh_dac_rp];
                    sh_dac_rp = palette_ptr_inc(sh_dac_rp);
                end
                PORT_PEL_MASK: r.data = (sh_pel == 8'h00) ? 8'hFF : sh_pel;
                default: r.pass = 1'b1;
            endcase
        end
        if (r.pass) r.data = 8'h00;
        return r;
    endfunction

    // Mostly decoded VGA ports, with index values biased into the
    // implemented ranges so data accesses reach the register files.
    function automatic t_access pick_access();
        t_access a;
        a.cmd = 1'($urandom_range(0, 1));
        a.value = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 12) begin
            a.port = 10'($urandom_range(0, 1023));
        end else begin
            a.port = VGA_PORTS[$urandom_range(0, NUM_VGA_PORTS - 1)];
            if (a.cmd == CMD_WRITE && $urandom_range(0, 99) < 80 &&
                a.port inside {PORT_CRTC_IDX_C, PORT_CRTC_IDX_M, PORT_GFX_IDX,
                               PORT_SEQ_IDX, PORT_ATT_IDX}) begin
                a.value = 8'($urandom_range(0, 27));
            end
            if (a.cmd == CMD_WRITE && $urandom_range(0, 99) < 30 &&
                (a.port == PORT_DAC_WIDX || a.port == PORT_DAC_RIDX)) begin
                a.value = 8'($urandom_range(250, 255));
            end
        end
        return a;
    endfunction

    task automatic send_access(input t_access a, input logic typed, input t_reply want);
        t_reply predicted;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, a.value, a.port, a.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = shadow_access(a);
        pending_replies.push_back(typed ? want : predicted);
        if (a.cmd == CMD_WRITE) n_writes++;
        else n_reads++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_status(input logic [7:0] s0, input logic [7:0] s1);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_STATUS0;
        i_cfg_wdata <= s0;
        @(posedge i_clk);
        i_cfg_index <= CFG_STATUS1;
        i_cfg_wdata <= s1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_status0 = s0;
        sh_status1 = s1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always begin
        @(hold_kick);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (m_axis_tuser) n_passed++;
            if (pending_replies.size() == 0) begin
                $error("result beat with nothing expected: read_data %02h passed_on %0b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                mon_want = pending_replies.pop_front();
                if (m_axis_tdata !== mon_want.data) begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           mon_want.data, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== mon_want.pass) begin
                    $error("passed_on mismatch: expected %0b, actual %0b",
                           mon_want.pass, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_replies.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_status(8'h5A, 8'hA5);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_access(DIRECTED_ROWS[r].acc, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 21;
                    sink_idle_pct = 70;
                    set_status(8'hFF, 8'h00);
                end
                1: begin
                    src_idle_pct = 70;
                    sink_idle_pct = 21;
                    set_status(8'h00, 8'hFF);
                end
                default: begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                    set_status(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // The sender stops here until every outstanding beat has returned.
                if (p == 0 && i == PHASE_ITEMS / 2) wait_drained();
                // The receiver stalls for a long stretch while beats keep coming.
                if (p == 2 && i == 40) -> hold_kick;
                send_access(pick_access(), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d port accesses (%0d reads, %0d writes); %0d results checked.",
                 n_reads + n_writes, n_reads, n_writes, n_results);
        $display("%0d accesses were passed on; status registers took four settings.",
                 n_passed);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
